/* rtl/pba_pkg.sv */
`timescale 1ns / 1ps
package pba_pkg;

  localparam int MAX_PAGES_DEF = 1024;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;
  localparam int SHIFT_W       = 5;
  localparam int TOTAL_W       = 11;
  localparam int ADDR_W        = 32;
  localparam int BYTES_W       = 27;
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd10;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
  localparam logic [TOTAL_W-1:0] FREE_MAX  = 11'h7FF;

  localparam logic [1:0] REG_PAGE_SHIFT   = 2'd0;
  localparam logic [1:0] REG_TOTAL_PAGES  = 2'd1;
  localparam logic [1:0] REG_KERNEL_START = 2'd2;
  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd3;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_INVALID = 2'd2
  } status_e;

  // Effective configuration: shift and total are already saturated.
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [TOTAL_W-1:0] total;
    logic [ADDR_W-1:0]  kernel_start;
    logic [ADDR_W-1:0]  kernel_size;
  } cfg_t;

endpackage

/* rtl/pba_ifs.sv */
`timescale 1ns / 1ps
interface pba_req_if import pba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

interface pba_rsp_if import pba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  page_address;
  logic [1:0]         status;
  logic [BYTES_W-1:0] free_bytes;
  logic [BYTES_W-1:0] total_bytes;

  modport source (output valid, output page_address, output status, output free_bytes,
                  output total_bytes, input ready);
  modport sink   (input valid, input page_address, input status, input free_bytes,
                  input total_bytes, output ready);
endinterface

/* rtl/pba_cfg_regs.sv */
`timescale 1ns / 1ps
module pba_cfg_regs import pba_pkg::*; #(
  parameter int MaxPages = MAX_PAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [SHIFT_W-1:0] shift_q;
  logic [TOTAL_W-1:0] total_q;
  logic [ADDR_W-1:0]  kstart_q;
  logic [ADDR_W-1:0]  ksize_q;
  logic [1:0]         reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 5'd12;
      total_q  <= 11'd1024;
      kstart_q <= 32'h0010_0000;
      ksize_q  <= 32'h0001_0000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAGE_SHIFT:   shift_q  <= pwdata[SHIFT_W-1:0];
        REG_TOTAL_PAGES:  total_q  <= pwdata[TOTAL_W-1:0];
        REG_KERNEL_START: kstart_q <= pwdata;
        REG_KERNEL_SIZE:  ksize_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAGE_SHIFT:   prdata = CFG_DATA_W'(shift_q);
      REG_TOTAL_PAGES:  prdata = CFG_DATA_W'(total_q);
      REG_KERNEL_START: prdata = kstart_q;
      REG_KERNEL_SIZE:  prdata = ksize_q;
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (shift_q < SHIFT_MIN) begin
      cfg_o.shift = SHIFT_MIN;
    end else if (shift_q > SHIFT_MAX) begin
      cfg_o.shift = SHIFT_MAX;
    end else begin
      cfg_o.shift = shift_q;
    end
    if (32'(total_q) > 32'(MaxPages)) begin
      cfg_o.total = TOTAL_W'(MaxPages);
    end else begin
      cfg_o.total = total_q;
    end
    cfg_o.kernel_start = kstart_q;
    cfg_o.kernel_size  = ksize_q;
  end

endmodule

/* rtl/pba_map_ram.sv */
`timescale 1ns / 1ps
module pba_map_ram import pba_pkg::*; #(
  parameter int Depth = MAX_PAGES_DEF / WORD_BITS,
  parameter int AddrW = $clog2(MAX_PAGES_DEF / WORD_BITS)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [Depth];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pba_ctrl.sv */
`timescale 1ns / 1ps
module pba_ctrl import pba_pkg::*; #(
  parameter  int MaxPages = MAX_PAGES_DEF,
  localparam int MapWords = (MaxPages + WORD_BITS - 1) / WORD_BITS,
  localparam int Aw       = (MapWords > 1) ? $clog2(MapWords) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  pba_req_if.sink              req,
  pba_rsp_if.source            rsp,
  output logic                 mem_we_o,
  output logic [Aw-1:0]        mem_waddr_o,
  output logic [WORD_BITS-1:0] mem_wdata_o,
  output logic [Aw-1:0]        mem_raddr_o,
  input  logic [WORD_BITS-1:0] mem_rdata_i
);

  localparam int Pw       = Aw + BIT_W;
  localparam int Cw       = (Aw + BIT_W + 1 > 12) ? Aw + BIT_W + 1 : 12;
  localparam logic [Aw-1:0] LastWord = Aw'(MapWords - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_A,
    S_INIT_B,
    S_SWEEP,
    S_ALLOC,
    S_FREE,
    S_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [Aw-1:0]      w_q, w_d;
  logic [BIT_W-1:0]   idx_q, idx_d;
  logic [TOTAL_W-1:0] free_q, free_d;
  logic [21:0]        kfirst_q, kfirst_d;
  logic [22:0]        kceil_q, kceil_d;
  logic [TOTAL_W-1:0] lo_q, lo_d;
  logic [TOTAL_W-1:0] hi_q, hi_d;
  logic [Pw-1:0]      res_page_q, res_page_d;
  status_e            res_stat_q, res_stat_d;
  logic               rsp_vld_q, rsp_vld_d;
  logic [ADDR_W-1:0]  rsp_page_q, rsp_page_d;
  status_e            rsp_stat_q, rsp_stat_d;
  logic [BYTES_W-1:0] rsp_free_q, rsp_free_d;
  logic [BYTES_W-1:0] rsp_total_q, rsp_total_d;

  cmd_e                 cmd;
  logic [ADDR_W-1:0]    free_page;
  logic                 free_oob;
  logic [Cw-1:0]        base;
  logic [Cw-1:0]        rem;
  logic [Cw-1:0]        last_w;
  logic                 is_last;
  logic [WORD_BITS-1:0] vmask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] pick;
  logic [BIT_W-1:0]     pick_idx;
  logic [32:0]          ksum;
  logic [23:0]          kend;
  logic [23:0]          tot24;
  logic [21:0]          klo;
  logic [5:0]           lo_off;
  logic [5:0]           hi_off;
  logic [WORD_BITS-1:0] sweep_mask;
  logic [TOTAL_W-1:0]   rng;
  logic                 page0_extra;
  logic [TOTAL_W-1:0]   init_free;

  assign cmd       = cmd_e'(req.command);
  assign free_page = req.address >> cfg_i.shift;
  assign free_oob  = free_page >= ADDR_W'(cfg_i.total);

  // Scan datapath: one map word per cycle, lowest clear page wins.
  always_comb begin
    base   = Cw'({w_q, {BIT_W{1'b0}}});
    rem    = Cw'(cfg_i.total) - base;
    last_w = Cw'((cfg_i.total - 11'd1) >> BIT_W);
    is_last = (Cw'(w_q) == last_w);
    if (rem >= Cw'(WORD_BITS)) begin
      vmask = '1;
    end else begin
      vmask = ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
    end
    // Page 0 is never handed out.
    if (w_q == '0) begin
      vmask[0] = 1'b0;
    end
    cand     = ~mem_rdata_i & vmask;
    pick     = cand & (~cand + 32'd1);
    pick_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (pick[b]) begin
        pick_idx = pick_idx | BIT_W'(b);
      end
    end
  end

  // Init datapath: kernel range bounds, per-word reserve mask and the final count.
  always_comb begin
    ksum  = {1'b0, cfg_i.kernel_size} + ((33'd1 << cfg_i.shift) - 33'd1);
    kend  = 24'(kfirst_q) + 24'(kceil_q);
    tot24 = 24'(cfg_i.total);
    klo   = (kfirst_q != '0) ? kfirst_q - 22'd1 : '0;

    if (Cw'(lo_q) <= base) begin
      lo_off = 6'd0;
    end else if (Cw'(lo_q) >= base + Cw'(WORD_BITS)) begin
      lo_off = 6'(WORD_BITS);
    end else begin
      lo_off = 6'(Cw'(lo_q) - base);
    end
    if (Cw'(hi_q) <= base) begin
      hi_off = 6'd0;
    end else if (Cw'(hi_q) >= base + Cw'(WORD_BITS)) begin
      hi_off = 6'(WORD_BITS);
    end else begin
      hi_off = 6'(Cw'(hi_q) - base);
    end
    sweep_mask = ({WORD_BITS{1'b1}} << lo_off) & ~({WORD_BITS{1'b1}} << hi_off);
    if (w_q == '0 && cfg_i.total != '0) begin
      sweep_mask[0] = 1'b1;
    end

    rng         = (hi_q > lo_q) ? hi_q - lo_q : '0;
    page0_extra = (cfg_i.total != '0) && !(lo_q == '0 && hi_q != '0);
    init_free   = cfg_i.total - rng - TOTAL_W'(page0_extra);
  end

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    idx_d       = idx_q;
    free_d      = free_q;
    kfirst_d    = kfirst_q;
    kceil_d     = kceil_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_page_d  = res_page_q;
    res_stat_d  = res_stat_q;
    rsp_vld_d   = rsp_vld_q && !rsp.ready;
    rsp_page_d  = rsp_page_q;
    rsp_stat_d  = rsp_stat_q;
    rsp_free_d  = rsp_free_q;
    rsp_total_d = rsp_total_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = w_q;
    mem_wdata_o = '0;
    mem_raddr_o = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we_o = 1'b1;
        if (w_q == LastWord) begin
          w_d     = '0;
          state_d = S_IDLE;
        end else begin
          w_d = w_q + Aw'(1);
        end
      end
      S_IDLE: begin
        if (cmd == CMD_FREE) begin
          mem_raddr_o = free_page[Aw+BIT_W-1:BIT_W];
        end
        if (req.valid) begin
          res_page_d = '0;
          res_stat_d = STAT_OK;
          w_d        = '0;
          case (cmd)
            CMD_INIT: state_d = S_INIT_A;
            CMD_ALLOC: begin
              if (cfg_i.total == '0) begin
                res_stat_d = STAT_OOM;
                state_d    = S_RESP;
              end else begin
                state_d = S_ALLOC;
              end
            end
            CMD_FREE: begin
              if (free_oob) begin
                res_stat_d = STAT_INVALID;
                state_d    = S_RESP;
              end else begin
                w_d     = free_page[Aw+BIT_W-1:BIT_W];
                idx_d   = free_page[BIT_W-1:0];
                state_d = S_FREE;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_INIT_A: begin
        kfirst_d = 22'(cfg_i.kernel_start >> cfg_i.shift);
        kceil_d  = 23'(ksum >> cfg_i.shift);
        state_d  = S_INIT_B;
      end
      S_INIT_B: begin
        hi_d    = (kend < tot24) ? TOTAL_W'(kend) : cfg_i.total;
        lo_d    = (24'(klo) < tot24) ? TOTAL_W'(klo) : cfg_i.total;
        w_d     = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = sweep_mask;
        if (w_q == LastWord) begin
          free_d  = init_free;
          state_d = S_RESP;
        end else begin
          w_d = w_q + Aw'(1);
        end
      end
      S_ALLOC: begin
        mem_raddr_o = w_q + Aw'(1);
        if (cand != '0) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i | pick;
          if (free_q != '0) begin
            free_d = free_q - 11'd1;
          end
          res_page_d = {w_q, pick_idx};
          state_d    = S_RESP;
        end else if (is_last) begin
          res_stat_d = STAT_OOM;
          state_d    = S_RESP;
        end else begin
          w_d = w_q + Aw'(1);
        end
      end
      S_FREE: begin
        if (mem_rdata_i[idx_q]) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i & ~(32'd1 << idx_q);
          if (free_q != FREE_MAX) begin
            free_d = free_q + 11'd1;
          end
        end else begin
          res_stat_d = STAT_INVALID;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!rsp_vld_q || rsp.ready) begin
          rsp_vld_d   = 1'b1;
          rsp_page_d  = ADDR_W'(48'(res_page_q) << cfg_i.shift);
          rsp_stat_d  = res_stat_q;
          rsp_free_d  = BYTES_W'({16'd0, free_q} << cfg_i.shift);
          rsp_total_d = BYTES_W'({16'd0, cfg_i.total} << cfg_i.shift);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      w_q         <= '0;
      idx_q       <= '0;
      free_q      <= '0;
      kfirst_q    <= '0;
      kceil_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      res_page_q  <= '0;
      res_stat_q  <= STAT_OK;
      rsp_vld_q   <= 1'b0;
      rsp_page_q  <= '0;
      rsp_stat_q  <= STAT_OK;
      rsp_free_q  <= '0;
      rsp_total_q <= '0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      idx_q       <= idx_d;
      free_q      <= free_d;
      kfirst_q    <= kfirst_d;
      kceil_q     <= kceil_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      res_page_q  <= res_page_d;
      res_stat_q  <= res_stat_d;
      rsp_vld_q   <= rsp_vld_d;
      rsp_page_q  <= rsp_page_d;
      rsp_stat_q  <= rsp_stat_d;
      rsp_free_q  <= rsp_free_d;
      rsp_total_q <= rsp_total_d;
    end
  end

  assign req.ready        = (state_q == S_IDLE);
  assign rsp.valid        = rsp_vld_q;
  assign rsp.page_address = rsp_page_q;
  assign rsp.status       = rsp_stat_q;
  assign rsp.free_bytes   = rsp_free_q;
  assign rsp.total_bytes  = rsp_total_q;

endmodule

/* rtl/page_bitmap_allocator_core.sv */
`timescale 1ns / 1ps
// Sequence: allocate scans W map words from word 0 up, W from 1 to ceil(total/32), one
// word per cycle through the single map read port; free reads the page's map word, then
// responds; init computes the kernel range, then writes every map word, one per cycle.
// Throughput: one transaction in flight; the next is taken once the result is registered.
// Reset: asynchronous; a clearing pass then zeroes every map word before the first request
// is taken. Configuration writes are taken at any time.
module page_bitmap_allocator_core import pba_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pba_req_if.sink               req_i,
  pba_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int MapWords = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int MapAw    = (MapWords > 1) ? $clog2(MapWords) : 1;

  cfg_t                 cfg;
  logic                 mem_we;
  logic [MapAw-1:0]     mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [MapAw-1:0]     mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  pba_cfg_regs #(
    .MaxPages (MAX_PAGES)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pba_map_ram #(
    .Depth (MapWords),
    .AddrW (MapAw)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pba_ctrl #(
    .MaxPages (MAX_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

/* rtl/pba_checker.sv */
`timescale 1ns / 1ps
module pba_sva import pba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [ADDR_W-1:0]  rsp_page_address_i,
  input logic [1:0]         rsp_status_i,
  input logic [BYTES_W-1:0] rsp_free_bytes_i,
  input logic [BYTES_W-1:0] rsp_total_bytes_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response transaction dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_page_address_i) && $stable(rsp_status_i)
      && $stable(rsp_free_bytes_i) && $stable(rsp_total_bytes_i))
    else $error("response payload changed while stalled");

  // Only a successful allocation carries a page address.
  a_addr_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != STAT_OK |-> rsp_page_address_i == '0)
    else $error("page address reported with a failing status");

  // Every response address and byte figure is a whole number of pages of at least 1 KiB.
  a_page_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_page_address_i[9:0] == '0 && rsp_free_bytes_i[9:0] == '0
      && rsp_total_bytes_i[9:0] == '0)
    else $error("response value not page aligned");

endmodule

bind page_bitmap_allocator_core pba_sva u_pba_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_page_address_i (rsp_o.page_address),
  .rsp_status_i       (rsp_o.status),
  .rsp_free_bytes_i   (rsp_o.free_bytes),
  .rsp_total_bytes_i  (rsp_o.total_bytes)
);
